>>> rtl/ll2ecef_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ll2ecef_pkg
// Shared widths, fixed-point constants and the arctangent table for the
// lat/lon to unit ECEF direction converter.
// ----------------------------------------------------------------------------
package ll2ecef_pkg;

	// fixed-point formats
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int OUT_FRAC_BITS   = 30;
	localparam int CORDIC_STAGES   = 24;

	// field widths
	localparam int LAT_W    = 24;
	localparam int LON_W    = 25;
	localparam int HGT_W    = 24;
	localparam int CFG_W    = 24;
	localparam int UNIT_W   = 32;
	localparam int RAD_W    = 32;
	localparam int S_TDATA_W = ((LAT_W + LON_W + HGT_W + 7) / 8) * 8;
	localparam int M_TDATA_W = 3 * UNIT_W + RAD_W;

	// internal widths
	localparam int ANG_W  = LON_W + 1;                  // angle before wrap
	localparam int RED_W  = LAT_W;                      // reduced angle, within +-90 deg
	localparam int PROD_W = 56;                         // reduced angle times pi/180
	localparam int CW     = 32;                         // cordic x, y, z in Q30
	localparam int RSUM_W = CFG_W + 1;                  // radius, never above 2^25

	// constants
	localparam logic signed [PROD_W-1:0] DEG_TO_RAD_Q36 = PROD_W'(1199381129);
	localparam logic signed [CW-1:0]     CORDIC_GAIN_Q30 = CW'(652032874);
	localparam logic signed [CW-1:0]     ONE_Q30 = CW'(1073741824);
	localparam logic [CFG_W-1:0]         RADIUS_RESET = CFG_W'(6371000);

	// atan(2^-i) in Q30
	localparam logic [CW-1:0] ATAN_Q30 [32] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

endpackage
`default_nettype wire

>>> rtl/ll2ecef_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ll2ecef_cordic
// Rotation-mode CORDIC, one register stage per iteration; gives the sine
// and cosine in Q30 of an angle in Q2.30 radians within +-pi/2.
// ----------------------------------------------------------------------------
module ll2ecef_cordic (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [ll2ecef_pkg::CW-1:0] z_in,     // angle, Q2.30 radians
	output logic signed [ll2ecef_pkg::CW-1:0] cos_out,  // Q30
	output logic signed [ll2ecef_pkg::CW-1:0] sin_out   // Q30
);
	import ll2ecef_pkg::*;

	logic signed [CW-1:0] x_s [CORDIC_STAGES];
	logic signed [CW-1:0] y_s [CORDIC_STAGES];
	logic signed [CW-1:0] z_s [CORDIC_STAGES];
	logic signed [CW-1:0] x_n [CORDIC_STAGES];
	logic signed [CW-1:0] y_n [CORDIC_STAGES];
	logic signed [CW-1:0] z_n [CORDIC_STAGES];

	// one micro-rotation per stage, toward z = 0
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		logic signed [CW-1:0] x_i;
		logic signed [CW-1:0] y_i;
		logic signed [CW-1:0] z_i;
		logic signed [CW-1:0] atan_i;

		if (i == 0) begin : g_first
			assign x_i = CORDIC_GAIN_Q30;
			assign y_i = '0;
			assign z_i = z_in;
		end else begin : g_next
			assign x_i = x_s[i-1];
			assign y_i = y_s[i-1];
			assign z_i = z_s[i-1];
		end

		assign atan_i = signed'(ATAN_Q30[i % 32]);

		always_comb begin
			if (!z_i[CW-1]) begin
				x_n[i] = x_i - (y_i >>> (i % 64));
				y_n[i] = y_i + (x_i >>> (i % 64));
				z_n[i] = z_i - atan_i;
			end else begin
				x_n[i] = x_i + (y_i >>> (i % 64));
				y_n[i] = y_i - (x_i >>> (i % 64));
				z_n[i] = z_i + atan_i;
			end
		end
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < CORDIC_STAGES; k++) begin
				x_s[k] <= x_n[k];
				y_s[k] <= y_n[k];
				z_s[k] <= z_n[k];
			end
		end
	end

	assign cos_out = x_s[CORDIC_STAGES-1];
	assign sin_out = y_s[CORDIC_STAGES-1];

endmodule
`default_nettype wire

>>> rtl/latlon_to_unit_ecef_top.sv
`default_nettype none
// Path: a request passes stages 1 to 3, the CORDIC stages, stages 4 and 5 and
// the output register before m_tvalid, and waits while m_tready holds it back.
// Throughput: one request per cycle unless the two-entry output buffer is full; the two
// CORDIC pipelines take a new angle every such cycle, and all stages stall while it is full.
// Reset: arst_n clears all valid bits and the output buffer and loads the
// earth radius register with 6371000 m; no clearing pass is needed.
// ----------------------------------------------------------------------------
// latlon_to_unit_ecef_top
// Converts latitude, longitude and height into a spherical unit direction in Q1.30
// and a radius of the earth radius register plus height, floored at 0; non-latlon gives 0.
// ----------------------------------------------------------------------------
module latlon_to_unit_ecef_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// configuration
	input  logic                                    cfg_we,
	input  logic [ll2ecef_pkg::CFG_W-1:0]           cfg_wdata,  // earth_radius_m
	// input stream
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [ll2ecef_pkg::S_TDATA_W-1:0]       s_tdata,    // latitude, longitude, height_m
	input  logic                                    s_tuser,    // is_latlon
	// output stream
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [ll2ecef_pkg::M_TDATA_W-1:0]       m_tdata,    // unit_x, unit_y, unit_z, radius_m
	output logic                                    m_tuser     // converted
);
	import ll2ecef_pkg::*;

	typedef struct packed {
		logic                    neg;
		logic signed [RED_W-1:0] r;
	} red_t;

	localparam logic signed [ANG_W-1:0] FULL_DEG    = ANG_W'(360 * 2**ANGLE_FRAC_BITS);
	localparam logic signed [ANG_W-1:0] HALF_DEG    = ANG_W'(180 * 2**ANGLE_FRAC_BITS);
	localparam logic signed [ANG_W-1:0] QUARTER_DEG = ANG_W'(90 * 2**ANGLE_FRAC_BITS);
	localparam int Z_SHIFT  = 6 + ANGLE_FRAC_BITS;
	localparam int XY_SHIFT = 60 - OUT_FRAC_BITS;
	localparam int SZ_SHIFT = 30 - OUT_FRAC_BITS;

	// wrap to [-180, 180) then fold into [-90, 90] with a sign flip
	function automatic red_t reduce_angle(input logic signed [ANG_W-1:0] a);
		logic signed [ANG_W-1:0] w;
		red_t res;
		w = a;
		if (w >= HALF_DEG)
			w = w - FULL_DEG;
		else if (w < -HALF_DEG)
			w = w + FULL_DEG;
		res.neg = 1'b0;
		if (w > QUARTER_DEG) begin
			w = w - HALF_DEG;
			res.neg = 1'b1;
		end else if (w < -QUARTER_DEG) begin
			w = w + HALF_DEG;
			res.neg = 1'b1;
		end
		res.r = w[RED_W-1:0];
		return res;
	endfunction

	// degrees times pi/180, rounded half away from zero to Q2.30
	function automatic logic signed [CW-1:0] round_z(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] sh;
		mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		sh  = (mag + (PROD_W'(1) << (Z_SHIFT - 1))) >> Z_SHIFT;
		return p[PROD_W-1] ? -signed'(sh[CW-1:0]) : signed'(sh[CW-1:0]);
	endfunction

	// generic round half away from zero by a constant shift
	function automatic logic signed [63:0] round_away(input logic signed [63:0] v,
			input int s);
		logic [63:0] mag;
		logic [63:0] half_lsb;
		mag      = v[63] ? 64'(-v) : 64'(v);
		half_lsb = (s == 0) ? 64'd0 : (64'd1 << (s - 1));
		mag      = (mag + half_lsb) >> s;
		return v[63] ? -signed'(mag) : signed'(mag);
	endfunction

	function automatic logic signed [CW-1:0] clamp_neg(input logic signed [CW-1:0] v,
			input logic neg);
		logic signed [CW-1:0] c;
		if (v > ONE_Q30)
			c = ONE_Q30;
		else if (v < -ONE_Q30)
			c = -ONE_Q30;
		else
			c = v;
		return neg ? -c : c;
	endfunction

	// earth radius register
	logic [CFG_W-1:0] radius_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_cfg_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			radius_cfg_q <= cfg_wdata;
		end
	end

	// pipeline advance, held while the output buffer is full
	logic adv;
	logic skid_v_q;

	assign adv      = !skid_v_q;
	assign s_tready = adv;

	// request field unpacking
	logic signed [LAT_W-1:0] lat_in;
	logic signed [LON_W-1:0] lon_in;
	logic signed [HGT_W-1:0] hgt_in;
	red_t                    lat_red;
	red_t                    lon_red;
	logic signed [RSUM_W:0]  rad_sum;

	assign lat_in  = s_tdata[LAT_W-1:0];
	assign lon_in  = s_tdata[LAT_W+LON_W-1:LAT_W];
	assign hgt_in  = s_tdata[LAT_W+LON_W+HGT_W-1:LAT_W+LON_W];
	assign lat_red = reduce_angle(ANG_W'(lat_in));
	assign lon_red = reduce_angle(ANG_W'(lon_in));
	assign rad_sum = signed'({2'b00, radius_cfg_q}) + (RSUM_W+1)'(hgt_in);

	// stage 1: angle reduction and radius
	logic                    v_s1;
	logic                    flag_s1;
	red_t                    lat_s1;
	red_t                    lon_s1;
	logic [RSUM_W-1:0]       rad_s1;

	// stage 2: conversion to radians
	logic                    v_s2;
	logic                    flag_s2;
	logic                    lat_neg_s2;
	logic                    lon_neg_s2;
	logic signed [PROD_W-1:0] lat_p_s2;
	logic signed [PROD_W-1:0] lon_p_s2;
	logic [RSUM_W-1:0]       rad_s2;

	// stage 3: rounding to Q2.30 radians
	logic                    v_s3;
	logic                    flag_s3;
	logic                    lat_neg_s3;
	logic                    lon_neg_s3;
	logic signed [CW-1:0]    lat_z_s3;
	logic signed [CW-1:0]    lon_z_s3;
	logic [RSUM_W-1:0]       rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flag_s1    <= s_tuser;
			lat_s1     <= lat_red;
			lon_s1     <= lon_red;
			rad_s1     <= rad_sum[RSUM_W] ? '0 : rad_sum[RSUM_W-1:0];

			flag_s2    <= flag_s1;
			lat_neg_s2 <= lat_s1.neg;
			lon_neg_s2 <= lon_s1.neg;
			lat_p_s2   <= PROD_W'(lat_s1.r) * DEG_TO_RAD_Q36;
			lon_p_s2   <= PROD_W'(lon_s1.r) * DEG_TO_RAD_Q36;
			rad_s2     <= rad_s1;

			flag_s3    <= flag_s2;
			lat_neg_s3 <= lat_neg_s2;
			lon_neg_s3 <= lon_neg_s2;
			lat_z_s3   <= round_z(lat_p_s2);
			lon_z_s3   <= round_z(lon_p_s2);
			rad_s3     <= rad_s2;
		end
	end

	// cordic pipelines, one per angle
	logic signed [CW-1:0] lat_cos;
	logic signed [CW-1:0] lat_sin;
	logic signed [CW-1:0] lon_cos;
	logic signed [CW-1:0] lon_sin;

	ll2ecef_cordic u_cordic_lat (
		.clk     (clk),
		.en      (adv),
		.z_in    (lat_z_s3),
		.cos_out (lat_cos),
		.sin_out (lat_sin)
	);

	ll2ecef_cordic u_cordic_lon (
		.clk     (clk),
		.en      (adv),
		.z_in    (lon_z_s3),
		.cos_out (lon_cos),
		.sin_out (lon_sin)
	);

	// side information travelling beside the cordic stages
	logic              cv_s     [CORDIC_STAGES];
	logic              cflag_s  [CORDIC_STAGES];
	logic              clatn_s  [CORDIC_STAGES];
	logic              clonn_s  [CORDIC_STAGES];
	logic [RSUM_W-1:0] crad_s   [CORDIC_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CORDIC_STAGES; k++)
				cv_s[k] <= 1'b0;
		end else if (adv) begin
			cv_s[0] <= v_s3;
			for (int k = 1; k < CORDIC_STAGES; k++)
				cv_s[k] <= cv_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cflag_s[0] <= flag_s3;
			clatn_s[0] <= lat_neg_s3;
			clonn_s[0] <= lon_neg_s3;
			crad_s[0]  <= rad_s3;
			for (int k = 1; k < CORDIC_STAGES; k++) begin
				cflag_s[k] <= cflag_s[k-1];
				clatn_s[k] <= clatn_s[k-1];
				clonn_s[k] <= clonn_s[k-1];
				crad_s[k]  <= crad_s[k-1];
			end
		end
	end

	// stage 4 (after the cordic stages): clamp and quadrant sign
	logic                 v_s4;
	logic                 flag_s4;
	logic signed [CW-1:0] sl_s4;
	logic signed [CW-1:0] cl_s4;
	logic signed [CW-1:0] so_s4;
	logic signed [CW-1:0] co_s4;
	logic [RSUM_W-1:0]    rad_s4;

	// stage 5: direction products
	logic                 v_s5;
	logic                 flag_s5;
	logic signed [63:0]   px_s5;
	logic signed [63:0]   py_s5;
	logic signed [CW-1:0] sl_s5;
	logic [RSUM_W-1:0]    rad_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s4 <= cv_s[CORDIC_STAGES-1];
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flag_s4 <= cflag_s[CORDIC_STAGES-1];
			sl_s4   <= clamp_neg(lat_sin, clatn_s[CORDIC_STAGES-1]);
			cl_s4   <= clamp_neg(lat_cos, clatn_s[CORDIC_STAGES-1]);
			so_s4   <= clamp_neg(lon_sin, clonn_s[CORDIC_STAGES-1]);
			co_s4   <= clamp_neg(lon_cos, clonn_s[CORDIC_STAGES-1]);
			rad_s4  <= crad_s[CORDIC_STAGES-1];

			flag_s5 <= flag_s4;
			px_s5   <= 64'(cl_s4) * 64'(co_s4);
			py_s5   <= 64'(cl_s4) * 64'(so_s4);
			sl_s5   <= sl_s4;
			rad_s5  <= rad_s4;
		end
	end

	// final rounding and packing of the result
	logic signed [63:0]     ux_r;
	logic signed [63:0]     uy_r;
	logic signed [63:0]     uz_r;
	logic [M_TDATA_W-1:0]   res_data;
	logic                   push;

	assign ux_r     = round_away(px_s5, XY_SHIFT);
	assign uy_r     = round_away(py_s5, XY_SHIFT);
	assign uz_r     = round_away(64'(sl_s5), SZ_SHIFT);
	assign res_data = flag_s5 ? {RAD_W'(rad_s5), uz_r[UNIT_W-1:0], uy_r[UNIT_W-1:0],
		ux_r[UNIT_W-1:0]} : '0;
	assign push     = adv && v_s5;

	// two-entry output buffer: output register plus skid entry
	logic                 out_v_q;
	logic [M_TDATA_W-1:0] out_data_q;
	logic                 out_user_q;
	logic [M_TDATA_W-1:0] skid_data_q;
	logic                 skid_user_q;
	logic                 pop;

	assign pop = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop)
				skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			out_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
				out_user_q <= skid_user_q;
			end
		end else if (!out_v_q || pop) begin
			out_data_q <= res_data;
			out_user_q <= flag_s5;
		end else if (push) begin
			skid_data_q <= res_data;
			skid_user_q <= flag_s5;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// checks
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid while output register empty");

	a_unconverted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("unconverted request carries nonzero payload");

	a_unit_z_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[3*UNIT_W-1:2*UNIT_W]) <= ONE_Q30 &&
		$signed(m_tdata[3*UNIT_W-1:2*UNIT_W]) >= -ONE_Q30))
		else $error("unit_z outside [-1, 1]");

	a_radius_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[M_TDATA_W-1:3*UNIT_W+RSUM_W] == '0))
		else $error("radius wider than earth radius plus height allows");

endmodule
`default_nettype wire
